>>> rtl/core/cbp_pkg.sv
// Shared types and constants of the cascaded balance PID unit.
// No dependencies; imported by cbp_mul and cascaded_balance_pid_unit.
`timescale 1ns / 1ps

package cbp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ANGLE_KP   = 3'd0;
    localparam logic [2:0] REG_ANGLE_KI   = 3'd1;
    localparam logic [2:0] REG_ANGLE_KD   = 3'd2;
    localparam logic [2:0] REG_SPEED_KP   = 3'd3;
    localparam logic [2:0] REG_SPEED_KI   = 3'd4;
    localparam logic [2:0] REG_SPEED_KD   = 3'd5;
    localparam logic [2:0] REG_REST_ANGLE = 3'd6;

    // Register reset values, Q16.16
    localparam logic signed [31:0] ANGLE_KP_RST   = 32'sd1179648;
    localparam logic signed [31:0] ANGLE_KI_RST   = 32'sd0;
    localparam logic signed [31:0] ANGLE_KD_RST   = 32'sd39322;
    localparam logic signed [31:0] SPEED_KP_RST   = -32'sd6554;
    localparam logic signed [31:0] SPEED_KI_RST   = -32'sd16384;
    localparam logic signed [31:0] SPEED_KD_RST   = 32'sd0;
    localparam logic signed [31:0] REST_ANGLE_RST = -32'sd65536;

    // Loop bounds, Q16.16 (500, 10, 100, 255)
    localparam logic signed [31:0] SPEED_IBOUND = 32'sd32768000;
    localparam logic signed [31:0] SPEED_OBOUND = 32'sd655360;
    localparam logic signed [31:0] ANGLE_IBOUND = 32'sd6553600;
    localparam logic signed [31:0] ANGLE_OBOUND = 32'sd16711680;

    // Widths of the shared multiplier path
    localparam int OPND_W = 33;
    localparam int PROD_W = 65;
    localparam int TERM_W = 49;
    localparam int ACC_W  = 51;

    // Request to the shared multiplier
    typedef struct packed {
        logic                     en;
        logic signed [31:0]       gain;
        logic signed [OPND_W-1:0] operand;
    } cbp_mul_req_t;

endpackage

>>> rtl/core/cbp_mul.sv
// Shared gain multiplier: registered Q16.16 x Q17.16 product, reduced to Q33.16
// with truncation toward zero. Depends on cbp_pkg.
`timescale 1ns / 1ps

module cbp_mul (
    input  logic                                   aclk,
    input  cbp_pkg::cbp_mul_req_t                  req,
    output logic signed [cbp_pkg::TERM_W-1:0]      term
);
    import cbp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;

    // Capture one product per request
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= PROD_W'($signed(req.gain)) * PROD_W'($signed(req.operand));
        end
    end

    // Divide by 2^16 toward zero: bias negative products before the shift
    assign biased  = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign shifted = biased >>> 16;
    assign term    = shifted[TERM_W-1:0];

endmodule

>>> rtl/core/cascaded_balance_pid_unit.sv
// Cascaded balance PID unit: outer speed PID feeds the angle target of an
// inner angle PID; one shared multiplier runs both loops under a sequencer.
// One item at a time: new input is accepted only after the last one is done.
// The sequencer runs a mean step, then per loop seven steps through the single
// multiplier (error, update, three products, sum, clamp), a target step between the
// loops and an output step. aresetn (sync, active low) clears gains to defaults, loop
// state to zero, and empties the output register. Depends on cbp_pkg and cbp_mul.
`timescale 1ns / 1ps

module cascaded_balance_pid_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] wheel_speed_left, [63:32] wheel_speed_right,
    // [95:64] tilt_angle, [127:96] speed_target
    input  logic [127:0] s_tdata,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // [8:0] motor_one_pwm, [17:9] motor_two_pwm, [49:18] angle_target, [55:50] zero
    output logic [55:0]  m_tdata
);
    import cbp_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_MEAN = 11'b00000000010,
        ST_ERR  = 11'b00000000100,
        ST_UPD  = 11'b00000001000,
        ST_MP   = 11'b00000010000,
        ST_MI   = 11'b00000100000,
        ST_MD   = 11'b00001000000,
        ST_ACC  = 11'b00010000000,
        ST_CLP  = 11'b00100000000,
        ST_TGT  = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [31:0] angle_kp_reg, angle_ki_reg, angle_kd_reg;
    logic signed [31:0] speed_kp_reg, speed_ki_reg, speed_kd_reg;
    logic signed [31:0] rest_angle_reg;

    // loop state
    logic signed [31:0] speed_integ_reg, speed_prev_reg;
    logic signed [31:0] angle_integ_reg, angle_prev_reg;

    // item working registers
    logic signed [31:0]     left_reg, right_reg, tilt_reg, target_reg;
    logic signed [31:0]     meas_reg, err_reg, pid_out_reg, atarget_reg;
    logic signed [32:0]     diff_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                   loop_reg;   // 0 speed loop, 1 angle loop

    // output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // datapath next values
    logic signed [32:0]      sum_lr, mean_wide;
    logic signed [31:0]      meas_next, err_next, integ_next, pid_out_next, atarget_next;
    logic signed [31:0]      minuend, subtrahend, integ_cur, prev_cur;
    logic signed [31:0]      ibound, obound;
    logic signed [32:0]      diff_next;
    logic signed [31:0]      kp_sel, ki_sel, kd_sel;
    logic signed [ACC_W-1:0] term_ext;
    logic signed [TERM_W-1:0] term;
    logic signed [31:0]      drive_biased, drive_shift;
    logic [8:0]              drive;
    cbp_mul_req_t            mul_req;
    logic                    out_free;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] v,
                                                     input logic signed [31:0] b);
        logic signed [31:0] r;
        if (v > b) begin
            r = b;
        end else if (v < -b) begin
            r = -b;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Select the active loop's operands and bounds
    always_comb begin
        minuend    = loop_reg ? tilt_reg        : meas_reg;
        subtrahend = loop_reg ? atarget_reg     : target_reg;
        integ_cur  = loop_reg ? angle_integ_reg : speed_integ_reg;
        prev_cur   = loop_reg ? angle_prev_reg  : speed_prev_reg;
        ibound     = loop_reg ? ANGLE_IBOUND    : SPEED_IBOUND;
        obound     = loop_reg ? ANGLE_OBOUND    : SPEED_OBOUND;
        kp_sel     = loop_reg ? angle_kp_reg    : speed_kp_reg;
        ki_sel     = loop_reg ? angle_ki_reg    : speed_ki_reg;
        kd_sel     = loop_reg ? angle_kd_reg    : speed_kd_reg;
    end

    // Mean wheel speed, truncated toward zero
    assign sum_lr    = {left_reg[31], left_reg} + {right_reg[31], right_reg};
    assign mean_wide = (sum_lr + (sum_lr[32] ? 33'sd1 : 33'sd0)) >>> 1;
    assign meas_next = mean_wide[31:0];

    // Error, integral, difference, target
    assign err_next     = sat32({minuend[31], minuend} - {subtrahend[31], subtrahend});
    assign integ_next   = clamp_sym({integ_cur[31], integ_cur} + {err_reg[31], err_reg},
                                    ibound);
    assign diff_next    = {err_reg[31], err_reg} - {prev_cur[31], prev_cur};
    assign atarget_next = sat32({rest_angle_reg[31], rest_angle_reg}
                                - {pid_out_reg[31], pid_out_reg});

    // Clamp the summed terms to the loop's output bound
    always_comb begin
        if (acc_reg > obound) begin
            pid_out_next = obound;
        end else if (acc_reg < -obound) begin
            pid_out_next = -obound;
        end else begin
            pid_out_next = acc_reg[31:0];
        end
    end

    // Drive: angle output to integer, toward zero
    assign drive_biased = pid_out_reg + (pid_out_reg[31] ? 32'sd65535 : 32'sd0);
    assign drive_shift  = drive_biased >>> 16;
    assign drive        = drive_shift[8:0];

    // Feed the shared multiplier: one term per product step
    always_comb begin
        mul_req.en      = 1'b0;
        mul_req.gain    = kp_sel;
        mul_req.operand = {err_reg[31], err_reg};
        case (state_reg)
            ST_MP: begin
                mul_req.en = 1'b1;
            end
            ST_MI: begin
                mul_req.en      = 1'b1;
                mul_req.gain    = ki_sel;
                mul_req.operand = {integ_cur[31], integ_cur};
            end
            ST_MD: begin
                mul_req.en      = 1'b1;
                mul_req.gain    = kd_sel;
                mul_req.operand = diff_reg;
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    cbp_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .term (term)
    );

    assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: state_next = ST_ERR;
            ST_ERR:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_MP;
            ST_MP:   state_next = ST_MI;
            ST_MI:   state_next = ST_MD;
            ST_MD:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_CLP;
            ST_CLP:  state_next = loop_reg ? ST_OUT : ST_TGT;
            ST_TGT:  state_next = ST_ERR;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_kp_reg   <= ANGLE_KP_RST;
            angle_ki_reg   <= ANGLE_KI_RST;
            angle_kd_reg   <= ANGLE_KD_RST;
            speed_kp_reg   <= SPEED_KP_RST;
            speed_ki_reg   <= SPEED_KI_RST;
            speed_kd_reg   <= SPEED_KD_RST;
            rest_angle_reg <= REST_ANGLE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ANGLE_KP:   angle_kp_reg   <= cfg_wdata;
                REG_ANGLE_KI:   angle_ki_reg   <= cfg_wdata;
                REG_ANGLE_KD:   angle_kd_reg   <= cfg_wdata;
                REG_SPEED_KP:   speed_kp_reg   <= cfg_wdata;
                REG_SPEED_KI:   speed_ki_reg   <= cfg_wdata;
                REG_SPEED_KD:   speed_kd_reg   <= cfg_wdata;
                REG_REST_ANGLE: rest_angle_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Loop state: integral and previous error of the active loop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_integ_reg <= '0;
            speed_prev_reg  <= '0;
            angle_integ_reg <= '0;
            angle_prev_reg  <= '0;
        end else if (state_reg == ST_UPD) begin
            if (loop_reg) begin
                angle_integ_reg <= integ_next;
                angle_prev_reg  <= err_reg;
            end else begin
                speed_integ_reg <= integ_next;
                speed_prev_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_reg <= 1'b0;
        end else if (state_reg == ST_MEAN) begin
            loop_reg <= 1'b0;
        end else if (state_reg == ST_TGT) begin
            loop_reg <= 1'b1;
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                left_reg   <= s_tdata[31:0];
                right_reg  <= s_tdata[63:32];
                tilt_reg   <= s_tdata[95:64];
                target_reg <= s_tdata[127:96];
            end
            ST_MEAN: meas_reg <= meas_next;
            ST_ERR:  err_reg  <= err_next;
            ST_UPD:  diff_reg <= diff_next;
            ST_MI:   acc_reg  <= term_ext;
            ST_MD:   acc_reg  <= acc_reg + term_ext;
            ST_ACC:  acc_reg  <= acc_reg + term_ext;
            ST_CLP:  pid_out_reg <= pid_out_next;
            ST_TGT:  atarget_reg <= atarget_next;
            default: begin
            end
        endcase
    end

    // Output register: load when the item finishes, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {6'd0, atarget_reg, drive, 9'(-drive)};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("finished item left the sequencer while the output was full");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result valid raised outside the output step");

    a_speed_integ: assert property (@(posedge aclk) disable iff (!aresetn)
        (speed_integ_reg <= SPEED_IBOUND) && (speed_integ_reg >= -SPEED_IBOUND))
        else $error("speed integral beyond its bound");

    a_angle_integ: assert property (@(posedge aclk) disable iff (!aresetn)
        (angle_integ_reg <= ANGLE_IBOUND) && (angle_integ_reg >= -ANGLE_IBOUND))
        else $error("angle integral beyond its bound");

    a_speed_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TGT) |->
            ((pid_out_reg <= SPEED_OBOUND) && (pid_out_reg >= -SPEED_OBOUND)))
        else $error("speed loop output beyond its bound");
`endif

endmodule
